/* rtl/mmat_pkg.sv */
// Shared types, constants and helpers for the multichannel moving average trend unit.
package mmat_pkg;

  localparam int CH_IDX_W    = 4;
  localparam int CHANNELS    = 1 << CH_IDX_W;
  localparam int HIST_DEPTH  = 4;
  localparam int SLOT_W      = 2;
  localparam int CNT_W       = 3;
  localparam int SAMPLE_BITS = 24;
  localparam int SUM_W       = SAMPLE_BITS + 3;
  localparam int DIV_SHIFT   = SUM_W + 3;
  localparam int RECIP_W     = DIV_SHIFT - 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((64'd1 << DIV_SHIFT) / 3);
  localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'((64'd1 << DIV_SHIFT) / 5);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_W-1:0]       sum_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [SLOT_W-1:0]      slot_t;

  typedef enum logic [1:0] {
    TREND_FLAT = 2'd0,
    TREND_UP   = 2'd1,
    TREND_DOWN = 2'd2
  } trend_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_WB
  } state_t;

  typedef struct packed {
    sample_t [HIST_DEPTH-1:0] hist;
    sample_t                  last_price;
    sample_t                  last_avg;
    cnt_t                     count;
    slot_t                    slot;
  } chan_state_t;

  function automatic trend_t trend_of(input sample_t now, input sample_t prev);
    trend_t t;
    if (now > prev) begin
      t = TREND_UP;
    end else if (now < prev) begin
      t = TREND_DOWN;
    end else begin
      t = TREND_FLAT;
    end
    return t;
  endfunction

endpackage

/* rtl/mmat_div.sv */
// Two-stage divider of the window sum by the sample count plus one (1 to 5).
module mmat_div (
  input  logic            clk,
  input  mmat_pkg::sum_t  sum_i,
  input  mmat_pkg::cnt_t  cnt_i,
  output mmat_pkg::sample_t quo_o
);
  import mmat_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  sum_t               sum_q_r;
  cnt_t               cnt_q_r;
  logic [RECIP_W-1:0] recip;
  sum_t               q_est;
  sum_t               q_times_d;
  sum_t               rem;
  sum_t               divisor;
  sum_t               quo;

  always_comb begin
    recip = (cnt_i == CNT_W'(2)) ? RECIP3 : RECIP5;
  end

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(sum_i) * PROD_W'(recip);
    sum_q_r <= sum_i;
    cnt_q_r <= cnt_i;
  end

  always_comb begin
    q_est     = SUM_W'(prod_r >> DIV_SHIFT);
    divisor   = SUM_W'(cnt_q_r) + SUM_W'(1);
    q_times_d = (cnt_q_r == CNT_W'(2)) ? ((q_est << 1) + q_est) : ((q_est << 2) + q_est);
    rem       = sum_q_r - q_times_d;
    unique case (cnt_q_r)
      CNT_W'(0): quo = sum_q_r;
      CNT_W'(1): quo = sum_q_r >> 1;
      CNT_W'(3): quo = sum_q_r >> 2;
      CNT_W'(2), CNT_W'(4): quo = (rem >= divisor) ? q_est + SUM_W'(1) : q_est;
      default: quo = sum_q_r >> 2;
    endcase
  end

  assign quo_o = quo[SAMPLE_BITS-1:0];

endmodule

/* rtl/multichannel_moving_average_trend_unit.sv */
// Top level: per-channel five-sample moving average with price and average trend flags.
// An accepted beat reads its entry from the single-port channel state memory, then passes the
// sum, multiply and write-back states; the result enters the output register at write-back and
// no new beat is taken before that. A held result stalls only the write-back step.
// Reset (rst_n low, synchronous): clears the sequencer, the output valid and the per-channel
// valid bits, so every channel reads as all zero until its first sample is written.
module multichannel_moving_average_trend_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [3:0] channel, [27:4] price, [31:28] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [3:0] channel_out, [5:4] price_trend, [29:6] average,
                                  // [31:30] average_trend
);
  import mmat_pkg::*;

  chan_state_t mem [CHANNELS];
  logic [CHANNELS-1:0] vld_r;

  state_t state_r, state_nxt;
  logic   mem_we;
  logic   out_load;
  logic   in_acc;

  logic [3:0]           chan_r;
  logic [CH_IDX_W-1:0]  idx_r;
  sample_t              price_r;
  chan_state_t          rd_r;
  logic                 rd_vld_r;
  chan_state_t          cur;
  chan_state_t          wr_state;
  sum_t                 sum_r;
  sum_t                 sum_nxt;
  sample_t              avg;
  trend_t               p_trend;
  trend_t               a_trend;

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;

  logic [SUM_W+CNT_W:0] chk_prod;
  logic [SUM_W+CNT_W:0] chk_div;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_WB;
      ST_WB:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_WB: begin
        mem_we   = !out_tvalid_r || out_tready;
        out_load = !out_tvalid_r || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      vld_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (mem_we) begin
        vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // capture the beat and read the channel entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r   <= in_tdata[3:0];
      idx_r    <= in_tdata[CH_IDX_W-1:0];
      price_r  <= in_tdata[4 +: SAMPLE_BITS];
      rd_r     <= mem[in_tdata[CH_IDX_W-1:0]];
      rd_vld_r <= vld_r[in_tdata[CH_IDX_W-1:0]];
    end
    if (mem_we) begin
      mem[idx_r] <= wr_state;
    end
  end

  assign cur = rd_vld_r ? rd_r : '0;

  always_comb begin
    sum_nxt = SUM_W'(price_r);
    for (int i = 0; i < HIST_DEPTH; i++) begin
      sum_nxt = sum_nxt + SUM_W'(cur.hist[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SUM) begin
      sum_r <= sum_nxt;
    end
  end

  mmat_div u_div (
    .clk   (clk),
    .sum_i (sum_r),
    .cnt_i (cur.count),
    .quo_o (avg)
  );

  assign p_trend = trend_of(price_r, cur.last_price);
  assign a_trend = trend_of(avg, cur.last_avg);

  always_comb begin
    wr_state                 = cur;
    wr_state.hist[cur.slot]  = price_r;
    wr_state.slot            = cur.slot + SLOT_W'(1);
    wr_state.last_price      = price_r;
    wr_state.last_avg        = avg;
    if (cur.count < CNT_W'(HIST_DEPTH)) begin
      wr_state.count = cur.count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {a_trend, avg, p_trend, chan_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign chk_prod = (SUM_W+CNT_W+1)'(avg) * (SUM_W+CNT_W+1)'(cur.count + CNT_W'(1));
  assign chk_div  = (SUM_W+CNT_W+1)'(cur.count + CNT_W'(1));

  a_div_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (chk_prod <= (SUM_W+CNT_W+1)'(sum_r)))
    else $error("average times divisor exceeds the window sum");

  a_div_high: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> ((SUM_W+CNT_W+1)'(sum_r) - chk_prod < chk_div))
    else $error("average remainder not below the divisor");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while a beat is in flight");

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) |-> (wr_state.count <= CNT_W'(HIST_DEPTH)))
    else $error("sample count past history depth");

  a_load_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_tvalid && state_r == ST_IDLE))
    else $error("result load did not end the sequence");

endmodule
